/* sv/tlzw_pkg.sv */
// ----------------------------------------------------------------------------
// tlzw_pkg: shared types and constants
// Code values, width limits and the request types that pass between the
// control sequencer, the dictionary memory and the bit packer.
// ----------------------------------------------------------------------------
package tlzw_pkg;

  localparam logic [11:0] CodeClear = 12'd256;
  localparam logic [11:0] CodeEoi   = 12'd257;
  localparam logic [11:0] CodeFirst = 12'd258;
  localparam logic [11:0] CodeLimit = 12'd4094;
  localparam logic [31:0] HashMul   = 32'd2654435761;
  localparam logic [3:0]  WidthMin  = 4'd9;
  localparam logic [3:0]  WidthMax  = 4'd12;
  localparam logic [7:0]  EpochNone = 8'd0;
  localparam logic [7:0]  EpochMax  = 8'd255;

  // One dictionary slot; epoch zero marks an empty slot.
  typedef struct packed {
    logic [7:0]  epoch;
    logic [19:0] key;
    logic [11:0] code;
  } slot_t;

  // Code request to the bit packer.
  typedef struct packed {
    logic        valid;
    logic [11:0] code;
    logic [3:0]  width;
    logic        last;
  } send_req_t;

endpackage

/* sv/tlzw_dict.sv */
// ----------------------------------------------------------------------------
// tlzw_dict: dictionary hash store
// Single-port-write, single-port-read synchronous memory of slots with a
// registered read.
// ----------------------------------------------------------------------------
module tlzw_dict #(
  parameter int SlotW = 13
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [SlotW-1:0]    rd_addr_i,
  input  logic                wr_en_i,
  input  logic [SlotW-1:0]    wr_addr_i,
  input  tlzw_pkg::slot_t     wr_data_i,
  output tlzw_pkg::slot_t     rd_data_o
);

  tlzw_pkg::slot_t mem_q [2**SlotW];
  tlzw_pkg::slot_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* sv/tlzw_pack.sv */
// ----------------------------------------------------------------------------
// tlzw_pack: MSB-first bit packer
// Appends variable-width codes to a bit buffer; emits one byte per cycle via
// an output register while not stalled; pads and flags a strip's final byte.
// ----------------------------------------------------------------------------
module tlzw_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlzw_pkg::send_req_t req_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          code_byte_o,
  output logic                strip_done_o
);

  logic [19:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        pend_q, pend_d;
  logic        ov_q, ov_d;
  logic [7:0]  byte_q, byte_d;
  logic        done_q, done_d;
  logic        load_ok;
  logic [31:0] shifted;
  logic [19:0] extract;
  logic [7:0]  pad;
  logic [4:0]  cnt_rem;

  assign ready_o = (cnt_q < 5'd8) && !pend_q;
  assign load_ok = !ov_q || !out_stall_i;
  assign cnt_rem = cnt_q - 5'd8;
  assign extract = buf_q >> cnt_rem;
  assign pad     = buf_q[7:0] << (5'd8 - cnt_q);
  assign shifted = {12'b0, buf_q} << req_i.width;

  always_comb begin
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    ov_d   = ov_q && out_stall_i;
    byte_d = byte_q;
    done_d = done_q;
    if (req_i.valid && ready_o) begin
      buf_d  = shifted[19:0] | {8'b0, req_i.code};
      cnt_d  = cnt_q + {1'b0, req_i.width};
      pend_d = req_i.last;
    end else if (load_ok) begin
      if (cnt_q >= 5'd8) begin
        ov_d   = 1'b1;
        byte_d = extract[7:0];
        done_d = pend_q && (cnt_rem == 5'd0);
        cnt_d  = cnt_rem;
        if (pend_q && cnt_rem == 5'd0) begin
          pend_d = 1'b0;
        end
      end else if (pend_q) begin
        // flush remaining bits zero-padded
        ov_d   = (cnt_q != 5'd0) || (ov_q && out_stall_i);
        byte_d = pad;
        done_d = 1'b1;
        cnt_d  = 5'd0;
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    byte_q <= byte_d;
    done_q <= done_d;
  end

  assign out_valid_o  = ov_q;
  assign code_byte_o  = byte_q;
  assign strip_done_o = done_q;

endmodule

/* sv/tiff_lzw_encoder.sv */
// ----------------------------------------------------------------------------
// tiff_lzw_encoder: TIFF LZW strip encoder
// Byte-in, packed-code-byte-out LZW compressor with a hashed dictionary.
// ----------------------------------------------------------------------------
// One byte is taken at a time; the block stalls its input until that byte's
// work is done. A byte that extends the open prefix passes through accept,
// hash multiply, memory read, compare and prefix update steps before the next
// byte is accepted; each extra linear probe repeats the memory read and
// compare. A byte that ends a match adds code send, code advance and new
// prefix steps; the send waits while the packer still holds a full byte,
// which it drains at one byte per cycle into the output register when the
// output is not stalled. The last byte of a strip then sends the prefix and
// EOI codes, and the packer pads the final byte. The dictionary memory is
// cleared by epoch tags; after reset, and after every 255 table clears, a
// sweep rewrites every memory slot before the next byte is taken.
module tiff_lzw_encoder #(
  parameter int HASH_SLOTS = 8192
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       strip_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] code_byte_o,
  output logic       strip_done_o
);

  localparam int SlotW = $clog2(HASH_SLOTS);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StHash  = 4'd1;
  localparam logic [3:0] StProbe = 4'd2;
  localparam logic [3:0] StCmp   = 4'd3;
  localparam logic [3:0] StSend  = 4'd4;
  localparam logic [3:0] StAdv   = 4'd5;
  localparam logic [3:0] StSetc  = 4'd6;
  localparam logic [3:0] StPost  = 4'd7;
  localparam logic [3:0] StEoi   = 4'd8;
  localparam logic [3:0] StFin   = 4'd9;
  localparam logic [3:0] StSweep = 4'd10;
  localparam logic [3:0] StFirst = 4'd11;

  logic [3:0]       st_q, st_d, ret_q, ret_d, adv_ret_q, adv_ret_d;
  logic [11:0]      prefix_q, prefix_d, free_q, free_d;
  logic [3:0]       width_q, width_d;
  logic [7:0]       epoch_q, epoch_d;
  logic             in_strip_q, in_strip_d, sweep_q, sweep_d;
  logic [7:0]       c_q, c_d;
  logic             last_q, last_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] idx_q, idx_d;
  tlzw_pkg::send_req_t req_q, req_d;

  logic             rd_en, wr_en, pack_ready;
  logic [SlotW-1:0] wr_addr;
  tlzw_pkg::slot_t  wr_data, rd_data;
  logic [19:0]      key;
  logic [35:0]      prod;
  logic [11:0]      next_free;
  logic [12:0]      width_lim;

  assign key       = {prefix_q, c_q};
  assign prod      = {16'b0, key} * {20'b0, tlzw_pkg::HashMul[15:0]};
  assign next_free = free_q + 12'd1;
  assign width_lim = 13'd1 << width_q;
  assign in_stall_o = (st_q != StIdle);

  always_comb begin
    st_d       = st_q;
    ret_d      = ret_q;
    adv_ret_d  = adv_ret_q;
    prefix_d   = prefix_q;
    free_d     = free_q;
    width_d    = width_q;
    epoch_d    = epoch_q;
    in_strip_d = in_strip_q;
    sweep_d    = sweep_q;
    c_d        = c_q;
    last_d     = last_q;
    slot_d     = slot_q;
    idx_d      = idx_q;
    req_d      = req_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = slot_q;
    wr_data    = '{epoch: epoch_q, key: key, code: free_q};
    if (req_q.valid && pack_ready) begin
      req_d.valid = 1'b0;
    end
    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          c_d    = data_byte_i;
          last_d = strip_end_i;
          if (!in_strip_q) begin
            req_d = '{valid: 1'b1, code: tlzw_pkg::CodeClear, width: width_q, last: 1'b0};
            ret_d = StFirst;
            st_d  = StSend;
          end else begin
            st_d = StHash;
          end
        end
      end
      StFirst: begin
        prefix_d   = {4'b0, c_q};
        in_strip_d = 1'b1;
        st_d       = StPost;
      end
      StHash: begin
        slot_d = prod[SlotW-1:0];
        st_d   = StProbe;
      end
      StProbe: begin
        rd_en = 1'b1;
        st_d  = StCmp;
      end
      StCmp: begin
        if (rd_data.epoch != epoch_q) begin
          // empty slot: store new pair, send open prefix
          wr_en     = 1'b1;
          req_d     = '{valid: 1'b1, code: prefix_q, width: width_q, last: 1'b0};
          ret_d     = StAdv;
          adv_ret_d = StSetc;
          st_d      = StSend;
        end else if (rd_data.key == key) begin
          prefix_d = rd_data.code;
          st_d     = StPost;
        end else begin
          slot_d = slot_q + 1'b1;
          st_d   = StProbe;
        end
      end
      StSend: begin
        if (pack_ready) begin
          st_d = ret_q;
        end
      end
      StAdv: begin
        free_d = next_free;
        st_d   = adv_ret_q;
        if (next_free >= tlzw_pkg::CodeLimit) begin
          req_d  = '{valid: 1'b1, code: tlzw_pkg::CodeClear, width: width_q, last: 1'b0};
          ret_d  = adv_ret_q;
          st_d   = StSend;
          free_d = tlzw_pkg::CodeFirst;
          width_d = tlzw_pkg::WidthMin;
          if (epoch_q == tlzw_pkg::EpochMax) begin
            epoch_d = 8'd1;
            sweep_d = 1'b1;
          end else begin
            epoch_d = epoch_q + 8'd1;
          end
        end else if (width_q < tlzw_pkg::WidthMax && {1'b0, next_free} >= width_lim) begin
          width_d = width_q + 4'd1;
        end
      end
      StSetc: begin
        prefix_d = {4'b0, c_q};
        st_d     = StPost;
      end
      StPost: begin
        if (last_q) begin
          req_d     = '{valid: 1'b1, code: prefix_q, width: width_q, last: 1'b0};
          ret_d     = StAdv;
          adv_ret_d = StEoi;
          st_d      = StSend;
        end else if (sweep_q) begin
          idx_d = '0;
          st_d  = StSweep;
        end else begin
          st_d = StIdle;
        end
      end
      StEoi: begin
        req_d = '{valid: 1'b1, code: tlzw_pkg::CodeEoi, width: width_q, last: 1'b1};
        ret_d = StFin;
        st_d  = StSend;
      end
      StFin: begin
        in_strip_d = 1'b0;
        prefix_d   = '0;
        free_d     = tlzw_pkg::CodeFirst;
        width_d    = tlzw_pkg::WidthMin;
        if (epoch_q == tlzw_pkg::EpochMax || sweep_q) begin
          epoch_d = 8'd1;
          idx_d   = '0;
          st_d    = StSweep;
        end else begin
          epoch_d = epoch_q + 8'd1;
          st_d    = StIdle;
        end
      end
      StSweep: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = '{epoch: tlzw_pkg::EpochNone, key: '0, code: '0};
        idx_d   = idx_q + 1'b1;
        if (idx_q == {SlotW{1'b1}}) begin
          sweep_d = 1'b0;
          st_d    = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StSweep;
      ret_q      <= StIdle;
      adv_ret_q  <= StIdle;
      prefix_q   <= '0;
      free_q     <= tlzw_pkg::CodeFirst;
      width_q    <= tlzw_pkg::WidthMin;
      epoch_q    <= 8'd1;
      in_strip_q <= 1'b0;
      sweep_q    <= 1'b1;
      idx_q      <= '0;
      req_q      <= '0;
    end else begin
      st_q       <= st_d;
      ret_q      <= ret_d;
      adv_ret_q  <= adv_ret_d;
      prefix_q   <= prefix_d;
      free_q     <= free_d;
      width_q    <= width_d;
      epoch_q    <= epoch_d;
      in_strip_q <= in_strip_d;
      sweep_q    <= sweep_d;
      idx_q      <= idx_d;
      req_q      <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    last_q <= last_d;
    slot_q <= slot_d;
  end

  tlzw_dict #(.SlotW(SlotW)) u_dict (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (slot_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  tlzw_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_q),
    .ready_o      (pack_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_byte_o  (code_byte_o),
    .strip_done_o (strip_done_o)
  );

endmodule
